@@ hdl/vtd_pkg.sv @@
package vtd_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int COEF_WIDTH  = 16;
    localparam int SLOT_BITS   = 16;
    localparam int NUM_COLS    = 4;
    localparam int NUM_LANES   = 3;
    localparam int REG_WIDTH   = 64;
    localparam int IDX_WIDTH   = 2;

    typedef enum logic [IDX_WIDTH-1:0] {
        REG_ROW0 = 2'd0,
        REG_ROW1 = 2'd1,
        REG_ROW2 = 2'd2,
        REG_ROW3 = 2'd3
    } t_reg_idx;

    // identity matrix in signed q4.12
    localparam logic [REG_WIDTH-1:0] ROW0_RESET = 64'h0000_0000_0000_1000;
    localparam logic [REG_WIDTH-1:0] ROW1_RESET = 64'h0000_0000_1000_0000;
    localparam logic [REG_WIDTH-1:0] ROW2_RESET = 64'h0000_1000_0000_0000;
    localparam logic [REG_WIDTH-1:0] ROW3_RESET = 64'h1000_0000_0000_0000;

    // per-item flags carried alongside the divide
    typedef struct packed {
        logic [NUM_LANES-1:0] neg;
        logic                 w_zero;
    } t_side;

endpackage

@@ hdl/vtd_div.sv @@
module vtd_div #(
    parameter int NW = 54,
    parameter int AW = 38
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [vtd_pkg::NUM_LANES-1:0][NW-1:0] i_num,
    input  logic [AW-1:0]                i_den,
    input  vtd_pkg::t_side               i_side,
    output logic                         o_valid,
    output logic [vtd_pkg::NUM_LANES-1:0][NW-1:0] o_quo,
    output vtd_pkg::t_side               o_side
);

    localparam int L = vtd_pkg::NUM_LANES;

    logic [NW-1:0]                 r_v;
    logic [NW-1:0][L-1:0][AW-1:0]  r_rem, n_rem;
    logic [NW-1:0][L-1:0][NW-1:0]  r_num, n_num;
    logic [NW-1:0][L-1:0][NW-1:0]  r_q,   n_q;
    logic [NW-1:0][AW-1:0]         r_den, n_den;
    vtd_pkg::t_side [NW-1:0]       r_side, n_side;
    logic [NW-1:0]                 n_v;

    // one quotient bit per stage, restoring
    always_comb begin
        logic [L-1:0][AW-1:0] s_rem;
        logic [L-1:0][NW-1:0] s_num;
        logic [L-1:0][NW-1:0] s_q;
        logic [AW-1:0]        s_den;
        logic [AW:0]          trial;
        for (int s = 0; s < NW; s++) begin
            if (s == 0) begin
                s_rem    = '0;
                s_num    = i_num;
                s_q      = '0;
                s_den    = i_den;
                n_side[s] = i_side;
                n_v[s]    = i_valid;
            end else begin
                s_rem    = r_rem[s-1];
                s_num    = r_num[s-1];
                s_q      = r_q[s-1];
                s_den    = r_den[s-1];
                n_side[s] = r_side[s-1];
                n_v[s]    = r_v[s-1];
            end
            n_den[s] = s_den;
            for (int l = 0; l < L; l++) begin
                trial = {s_rem[l], s_num[l][NW-1]};
                if (trial >= {1'b0, s_den}) begin
                    n_rem[s][l] = AW'(trial - {1'b0, s_den});
                    n_q[s][l]   = {s_q[l][NW-2:0], 1'b1};
                end else begin
                    n_rem[s][l] = trial[AW-1:0];
                    n_q[s][l]   = {s_q[l][NW-2:0], 1'b0};
                end
                n_num[s][l] = {s_num[l][NW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_num  <= n_num;
            r_q    <= n_q;
            r_den  <= n_den;
            r_side <= n_side;
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_quo   = r_q[NW-1];
    assign o_side  = r_side[NW-1];

endmodule

@@ hdl/vertex_transform_divide.sv @@
// pipeline: product, row sum and magnitude stages, then the divide stages and the
//   result register; one bit of every quotient is settled per divide stage
// throughput: one vertex per cycle; the whole pipeline holds while the result
//   register is full and not taken
// reset: synchronous active low; clears valid bits and loads the identity matrix
module vertex_transform_divide #(
    parameter int COORD_WIDTH = vtd_pkg::COORD_WIDTH,
    parameter int COEF_WIDTH  = vtd_pkg::COEF_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [vtd_pkg::IDX_WIDTH-1:0]       i_cfg_index,
    input  logic [vtd_pkg::REG_WIDTH-1:0]       i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [COORD_WIDTH-1:0]       i_pos_x,
    input  logic signed [COORD_WIDTH-1:0]       i_pos_y,
    input  logic signed [COORD_WIDTH-1:0]       i_pos_z,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [COORD_WIDTH-1:0]       o_out_x,
    output logic signed [COORD_WIDTH-1:0]       o_out_y,
    output logic signed [COORD_WIDTH-1:0]       o_out_z,
    output logic                                o_w_zero,
    output logic                                o_saturated
);

    localparam int L     = vtd_pkg::NUM_LANES;
    localparam int R     = vtd_pkg::NUM_COLS;
    localparam int CF    = COORD_WIDTH / 2;      // coordinate fraction bits
    localparam int KF    = COEF_WIDTH - 4;       // coefficient fraction bits
    localparam int PW    = COORD_WIDTH + COEF_WIDTH;
    localparam int SW    = PW + 2;               // row sum width
    localparam int XW    = SW - KF;              // shifted row sum width
    localparam int AW    = XW;                   // magnitude width
    localparam int NW    = AW + CF;              // numerator width
    localparam logic [NW-1:0] LIM = NW'(1) << (COORD_WIDTH - 1);

    // matrix registers
    logic [R-1:0][vtd_pkg::REG_WIDTH-1:0] r_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= vtd_pkg::ROW0_RESET;
            r_row[1] <= vtd_pkg::ROW1_RESET;
            r_row[2] <= vtd_pkg::ROW2_RESET;
            r_row[3] <= vtd_pkg::ROW3_RESET;
        end else if (i_cfg_we) begin
            unique case (vtd_pkg::t_reg_idx'(i_cfg_index))
                vtd_pkg::REG_ROW0: r_row[0] <= i_cfg_data;
                vtd_pkg::REG_ROW1: r_row[1] <= i_cfg_data;
                vtd_pkg::REG_ROW2: r_row[2] <= i_cfg_data;
                vtd_pkg::REG_ROW3: r_row[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: the pipeline moves when the result register can take data
    logic r_out_valid;
    logic en;
    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    // stage 1: twelve products plus the translation terms
    logic                              r_v1;
    logic [R-1:0][L-1:0][PW-1:0]       r_prod, n_prod;
    logic [R-1:0][SW-1:0]              r_trans, n_trans;

    always_comb begin
        logic signed [COEF_WIDTH-1:0]  c;
        logic signed [COORD_WIDTH-1:0] p;
        for (int r = 0; r < R; r++) begin
            for (int j = 0; j < L; j++) begin
                c = $signed(r_row[r][j*vtd_pkg::SLOT_BITS +: COEF_WIDTH]);
                p = (j == 0) ? i_pos_x : ((j == 1) ? i_pos_y : i_pos_z);
                n_prod[r][j] = PW'(c * p);
            end
            c = $signed(r_row[r][L*vtd_pkg::SLOT_BITS +: COEF_WIDTH]);
            n_trans[r] = SW'($signed(SW'(c)) <<< CF);
        end
    end

    // stage 2: row sums, floor shift to coordinate format
    logic                   r_v2;
    logic [R-1:0][XW-1:0]   r_sum, n_sum;

    always_comb begin
        logic signed [SW-1:0] acc;
        for (int r = 0; r < R; r++) begin
            acc = $signed(r_trans[r]);
            for (int j = 0; j < L; j++) begin
                acc = acc + SW'($signed(r_prod[r][j]));
            end
            n_sum[r] = XW'(acc >>> KF);
        end
    end

    // stage 3: magnitudes, signs and the w zero flag
    logic                         r_v3;
    logic [L-1:0][NW-1:0]         r_num, n_num;
    logic [AW-1:0]                r_den, n_den;
    vtd_pkg::t_side               r_side3, n_side3;

    always_comb begin
        logic [XW-1:0] w;
        logic [XW-1:0] mag;
        w      = r_sum[R-1];
        n_den  = w[XW-1] ? AW'(0 - w) : AW'(w);
        n_side3.w_zero = (w == '0);
        for (int j = 0; j < L; j++) begin
            mag = r_sum[j][XW-1] ? XW'(0 - r_sum[j]) : r_sum[j];
            n_num[j] = NW'(mag) << CF;
            n_side3.neg[j] = r_sum[j][XW-1] ^ w[XW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod  <= n_prod;
            r_trans <= n_trans;
            r_sum   <= n_sum;
            r_num   <= n_num;
            r_den   <= n_den;
            r_side3 <= n_side3;
        end
    end

    // divide stages, three quotients against one shared w
    logic                   div_valid;
    logic [L-1:0][NW-1:0]   div_quo;
    vtd_pkg::t_side         div_side;

    vtd_div #(
        .NW (NW),
        .AW (AW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v3),
        .i_num   (r_num),
        .i_den   (r_den),
        .i_side  (r_side3),
        .o_valid (div_valid),
        .o_quo   (div_quo),
        .o_side  (div_side)
    );

    // final stage: sign, clamp, w zero override
    logic [L-1:0][COORD_WIDTH-1:0] r_res, n_res;
    logic                          r_wz, r_sat, n_sat;

    always_comb begin
        logic [NW-1:0] q;
        n_sat = 1'b0;
        for (int j = 0; j < L; j++) begin
            q = div_quo[j];
            if (div_side.neg[j]) begin
                if (q > LIM) begin
                    q     = LIM;
                    n_sat = 1'b1;
                end
                n_res[j] = COORD_WIDTH'(0 - q);
            end else begin
                if (q > LIM - NW'(1)) begin
                    q     = LIM - NW'(1);
                    n_sat = 1'b1;
                end
                n_res[j] = COORD_WIDTH'(q);
            end
            if (div_side.w_zero) begin
                n_res[j] = '0;
            end
        end
        if (div_side.w_zero) begin
            n_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= n_res;
            r_wz  <= div_side.w_zero;
            r_sat <= n_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_x     = $signed(r_res[0]);
    assign o_out_y     = $signed(r_res[1]);
    assign o_out_z     = $signed(r_res[2]);
    assign o_w_zero    = r_wz;
    assign o_saturated = r_sat;

endmodule

@@ verif/testbench.sv @@
module testbench;

    // result fields of one vertex, as the block should present them
    typedef struct {
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic [31:0] out_z;
        logic        w_zero;
        logic        saturated;
    } t_vertex_result;

    localparam int DRAIN_CYCLES = 70;      // idle wait after the last result, before the matrix is touched
    localparam int CYCLE_LIMIT  = 600000;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [vtd_pkg::IDX_WIDTH-1:0] i_cfg_index;
    logic [vtd_pkg::REG_WIDTH-1:0] i_cfg_data;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic signed [31:0]            i_pos_x;
    logic signed [31:0]            i_pos_y;
    logic signed [31:0]            i_pos_z;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic signed [31:0]            o_out_x;
    logic signed [31:0]            o_out_y;
    logic signed [31:0]            o_out_z;
    logic                          o_w_zero;
    logic                          o_saturated;

    // our own copy of the matrix rows
    logic [vtd_pkg::REG_WIDTH-1:0] matrix_rows [4];
    t_vertex_result                pending_vertices [$];
    int                            error_count;
    int                            idle_mode;  // 0: receiver often stalls, 1: sender often idles, 2: no idling
    int                            hold_left;  // long receiver hold-off, counted down below
    int                            cycle_count;

    vertex_transform_divide dut (.*);

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    // one matrix row dotted with (x, y, z, 1), shifted down to q16.16
    function automatic longint row_dot(logic [vtd_pkg::REG_WIDTH-1:0] row, longint x,
                                       longint y, longint z);
        longint c0, c1, c2, c3, acc;
        c0 = longint'($signed(row[15:0]));
        c1 = longint'($signed(row[31:16]));
        c2 = longint'($signed(row[47:32]));
        c3 = longint'($signed(row[63:48]));
        acc = c0 * x + c1 * y + c2 * z + (c3 <<< 16);
        return acc >>> 12;
    endfunction

    // truncating divide with clamp; bit 32 is the clamp flag
    function automatic logic [32:0] divide_clamp(longint num, longint den);
        logic                  neg;
        longint unsigned       an, ad, q, lim;
        logic                  sat;
        neg = (num < 0) != (den < 0);
        an  = (num < 0) ? longint'(-num) : num;
        ad  = (den < 0) ? longint'(-den) : den;
        lim = 64'd1 << 31;
        q   = (an << 16) / ad;
        sat = 1'b0;
        if (!neg) begin
            if (q > lim - 1) begin
                q   = lim - 1;
                sat = 1'b1;
            end
        end else begin
            if (q > lim) begin
                q   = lim;
                sat = 1'b1;
            end
            q = -q;
        end
        return {sat, q[31:0]};
    endfunction

    function automatic t_vertex_result transform_vertex(logic [31:0] x, logic [31:0] y,
                                                        logic [31:0] z);
        t_vertex_result r;
        longint sx, sy, sz, tx, ty, tz, tw;
        logic [32:0] qx, qy, qz;
        sx = longint'($signed(x));
        sy = longint'($signed(y));
        sz = longint'($signed(z));
        tx = row_dot(matrix_rows[vtd_pkg::REG_ROW0], sx, sy, sz);
        ty = row_dot(matrix_rows[vtd_pkg::REG_ROW1], sx, sy, sz);
        tz = row_dot(matrix_rows[vtd_pkg::REG_ROW2], sx, sy, sz);
        tw = row_dot(matrix_rows[vtd_pkg::REG_ROW3], sx, sy, sz);
        if (tw == 0) begin
            // w zero: outputs forced to zero, flag raised
            r = '{32'd0, 32'd0, 32'd0, 1'b1, 1'b0};
        end else begin
            qx = divide_clamp(tx, tw);
            qy = divide_clamp(ty, tw);
            qz = divide_clamp(tz, tw);
            r = '{qx[31:0], qy[31:0], qz[31:0], 1'b0, qx[32] | qy[32] | qz[32]};
        end
        return r;
    endfunction

    // ------------------------------------------------------------------ checker

    always @(posedge i_clk) begin
        t_vertex_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_vertices.size() == 0) begin
                $error("result transfer with no vertex outstanding");
                error_count++;
            end else begin
                want = pending_vertices.pop_front();
                if (o_out_x !== want.out_x) begin
                    $error("out_x expected %h actual %h", want.out_x, o_out_x);
                    error_count++;
                end
                if (o_out_y !== want.out_y) begin
                    $error("out_y expected %h actual %h", want.out_y, o_out_y);
                    error_count++;
                end
                if (o_out_z !== want.out_z) begin
                    $error("out_z expected %h actual %h", want.out_z, o_out_z);
                    error_count++;
                end
                if (o_w_zero !== want.w_zero) begin
                    $error("w_zero expected %b actual %b", want.w_zero, o_w_zero);
                    error_count++;
                end
                if (o_saturated !== want.saturated) begin
                    $error("saturated expected %b actual %b", want.saturated, o_saturated);
                    error_count++;
                end
            end
        end
    end

    // receiver side, ready changes on the falling edge
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            case (idle_mode)
                0: begin
                    i_out_ready <= ($urandom_range(0, 99) >= 64);
                end
                1: begin
                    i_out_ready <= ($urandom_range(0, 99) >= 22);
                end
                default: begin
                    i_out_ready <= 1'b1;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- drivers

    // one vertex transfer; called and returns on a falling edge
    task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int idle_pct;
        idle_pct = (idle_mode == 0) ? 22 : ((idle_mode == 1) ? 64 : 0);
        // each cycle idles with the same chance
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pos_x    <= x;
        i_pos_y    <= y;
        i_pos_z    <= z;
        do @(posedge i_clk); while (!o_in_ready);
        pending_vertices.insert(pending_vertices.size(), transform_vertex(x, y, z));
        @(negedge i_clk);
    endtask

    // wait for the pipeline to empty before touching the matrix
    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending_vertices.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // leaves the write enable high; the caller lowers it after the last row
    task automatic write_row(vtd_pkg::t_reg_idx idx, logic [vtd_pkg::REG_WIDTH-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        matrix_rows[idx] = value;
        @(negedge i_clk);
    endtask

    task automatic load_matrix(logic [vtd_pkg::REG_WIDTH-1:0] r0,
                               logic [vtd_pkg::REG_WIDTH-1:0] r1,
                               logic [vtd_pkg::REG_WIDTH-1:0] r2,
                               logic [vtd_pkg::REG_WIDTH-1:0] r3);
        drain();
        write_row(vtd_pkg::REG_ROW0, r0);
        write_row(vtd_pkg::REG_ROW1, r1);
        write_row(vtd_pkg::REG_ROW2, r2);
        write_row(vtd_pkg::REG_ROW3, r3);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'sd0 + $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            3: return 32'h0001_0000 * $urandom_range(0, 15);
            default: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
        endcase
    endfunction

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 4))
            0: return 16'($urandom());
            1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            2: return 16'h1000;
            default: return 16'(int'($urandom_range(0, 16'h2000)) - 16'h1000);
        endcase
    endfunction

    function automatic logic [vtd_pkg::REG_WIDTH-1:0] pick_row();
        return {pick_coef(), pick_coef(), pick_coef(), pick_coef()};
    endfunction

    // ------------------------------------------------------------------ tests

    task automatic test_identity_extremes;
        idle_mode = 2;
        send_vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000);
        send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
        send_vertex(32'hffff_ffff, 32'h0000_0001, 32'h8000_0000);
        send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    endtask

    task automatic test_w_zero;
        // w row all zero
        load_matrix(vtd_pkg::ROW0_RESET, vtd_pkg::ROW1_RESET, vtd_pkg::ROW2_RESET, 64'd0);
        send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678);
        // w = x, zero only where x is zero
        load_matrix(vtd_pkg::ROW0_RESET, vtd_pkg::ROW1_RESET, vtd_pkg::ROW2_RESET,
                    64'h0000_0000_0000_1000);
        send_vertex(32'h0000_0000, 32'h0005_0000, 32'hfff0_0000);
        send_vertex(32'h0000_0fff, 32'h0005_0000, 32'hfff0_0000);
        send_vertex(32'hffff_ffff, 32'h0005_0000, 32'hfff0_0000);
    endtask

    task automatic test_clamp;
        // tiny w, large numerators: both clamp bounds
        load_matrix(64'h0000_7fff_7fff_7fff, 64'h0000_8000_8000_8000,
                    64'h7fff_0000_0000_0000, 64'h0001_0000_0000_0000);
        send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vertex(32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
        // negative w, extreme coefficients
        load_matrix(64'h8000_8000_8000_8000, 64'h7fff_7fff_7fff_7fff,
                    64'h8000_7fff_8000_7fff, 64'h8000_0000_0000_0001);
        send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000);
        send_vertex(32'hffff_0000, 32'h0000_ffff, 32'h0000_0000);
        send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    endtask

    // random matrices; w row mostly well away from zero so quotients stay meaningful
    task automatic test_random_phase(int mode, int n);
        logic [vtd_pkg::REG_WIDTH-1:0] wrow;
        idle_mode = mode;
        for (int m = 0; m < 6; m++) begin
            wrow = pick_row();
            if ($urandom_range(0, 3) != 0) wrow[63:48] = 16'($urandom_range(16'h0400, 16'h4000));
            if ($urandom_range(0, 5) == 0) wrow = 64'd0;
            load_matrix(pick_row(), pick_row(), pick_row(), wrow);
            for (int i = 0; i < n / 6; i++) send_vertex(pick_coord(), pick_coord(), pick_coord());
        end
    endtask

    // receiver stops for a long stretch while vertices keep coming
    task automatic test_backpressure;
        load_matrix(vtd_pkg::ROW0_RESET, vtd_pkg::ROW1_RESET, vtd_pkg::ROW2_RESET,
                    vtd_pkg::ROW3_RESET);
        idle_mode = 2;
        hold_left = 400;
        for (int i = 0; i < 150; i++) send_vertex(pick_coord(), pick_coord(), pick_coord());
    endtask

    initial begin
        error_count = 0;
        cycle_count = 0;
        idle_mode   = 2;
        hold_left   = 0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_pos_x     = '0;
        i_pos_y     = '0;
        i_pos_z     = '0;
        i_out_ready = 1'b0;
        matrix_rows[vtd_pkg::REG_ROW0] = vtd_pkg::ROW0_RESET;
        matrix_rows[vtd_pkg::REG_ROW1] = vtd_pkg::ROW1_RESET;
        matrix_rows[vtd_pkg::REG_ROW2] = vtd_pkg::ROW2_RESET;
        matrix_rows[vtd_pkg::REG_ROW3] = vtd_pkg::ROW3_RESET;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_identity_extremes();
        test_w_zero();
        test_clamp();
        test_random_phase(0, 540);
        test_random_phase(1, 540);
        test_random_phase(2, 540);
        test_backpressure();

        drain();
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/vtd_pkg.sv
hdl/vtd_div.sv
hdl/vertex_transform_divide.sv
verif/testbench.sv
